// ----- rtl/core/numeric_token_type_inference_core_defines.svh -----
// Assertion helpers used by the RTL of the numeric token type inference core.
`ifndef NUMERIC_TOKEN_TYPE_INFERENCE_CORE_DEFINES_SVH
`define NUMERIC_TOKEN_TYPE_INFERENCE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NTTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntti check failed");

// Next-cycle implication, checked outside reset.
`define NTTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntti check failed");

`endif

// ----- rtl/core/ntti_pkg.sv -----
package ntti_pkg;

    localparam int unsigned CODE_W = 21;

    localparam logic [CODE_W-1:0] C_PLUS  = CODE_W'(8'h2B);
    localparam logic [CODE_W-1:0] C_MINUS = CODE_W'(8'h2D);
    localparam logic [CODE_W-1:0] C_DOT   = CODE_W'(8'h2E);
    localparam logic [CODE_W-1:0] C_ZERO  = CODE_W'(8'h30);
    localparam logic [CODE_W-1:0] C_NINE  = CODE_W'(8'h39);
    localparam logic [CODE_W-1:0] C_EXP_U = CODE_W'(8'h45);
    localparam logic [CODE_W-1:0] C_EXP_L = CODE_W'(8'h65);

    // Recognizer phase of the open word.
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SIGNED  = 3'd1,
        PH_INT     = 3'd2,
        PH_FRAC    = 3'd3,
        PH_EXP     = 3'd4,
        PH_EXPSIGN = 3'd5,
        PH_EXPDIG  = 3'd6,
        PH_BAD     = 3'd7
    } t_phase;

    // Ordered so that a larger code is a worse class.
    typedef enum logic [1:0] {
        CLS_INT    = 2'd0,
        CLS_FLOAT  = 2'd1,
        CLS_STRING = 2'd2
    } t_class;

    typedef struct packed {
        logic              has_char;
        logic [CODE_W-1:0] char_code;
        logic              word_end;
        logic              last_word;
    } t_item;

    // Outcome of one item applied to the recognizer state.
    typedef struct packed {
        t_phase phase;
        t_class cls;
        t_class result;
    } t_step;

endpackage

// ----- rtl/core/ntti_stream_if.sv -----
interface ntti_in_if;
    logic                      valid;
    logic                      ready;
    logic                      has_char;
    logic [ntti_pkg::CODE_W-1:0] char_code;
    logic                      word_end;
    logic                      last_word;

    modport source (output valid, has_char, char_code, word_end, last_word, input ready);
    modport sink   (input valid, has_char, char_code, word_end, last_word, output ready);
endinterface

interface ntti_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] data_type;

    modport source (output valid, data_type, input ready);
    modport sink   (input valid, data_type, output ready);
endinterface

// ----- rtl/core/ntti_step.sv -----
module ntti_step (
    input  ntti_pkg::t_phase i_phase,
    input  ntti_pkg::t_class i_class,
    input  ntti_pkg::t_item  i_item,
    output ntti_pkg::t_step  o_step
);

    logic             is_digit;
    logic             is_sign;
    logic             is_exp;
    logic             is_dot;
    ntti_pkg::t_phase char_phase;
    ntti_pkg::t_phase word_phase;
    ntti_pkg::t_class grade;
    ntti_pkg::t_class merged;

    assign is_digit = (i_item.char_code >= ntti_pkg::C_ZERO) &&
                      (i_item.char_code <= ntti_pkg::C_NINE);
    assign is_sign  = (i_item.char_code == ntti_pkg::C_PLUS) ||
                      (i_item.char_code == ntti_pkg::C_MINUS);
    assign is_exp   = (i_item.char_code == ntti_pkg::C_EXP_U) ||
                      (i_item.char_code == ntti_pkg::C_EXP_L);
    assign is_dot   = (i_item.char_code == ntti_pkg::C_DOT);

    always_comb begin
        char_phase = ntti_pkg::PH_BAD;
        unique case (i_phase)
            ntti_pkg::PH_START: begin
                if (is_sign)       char_phase = ntti_pkg::PH_SIGNED;
                else if (is_digit) char_phase = ntti_pkg::PH_INT;
                else if (is_dot)   char_phase = ntti_pkg::PH_FRAC;
            end
            ntti_pkg::PH_SIGNED, ntti_pkg::PH_INT: begin
                if (is_digit)      char_phase = ntti_pkg::PH_INT;
                else if (is_dot)   char_phase = ntti_pkg::PH_FRAC;
            end
            ntti_pkg::PH_FRAC: begin
                if (is_digit)      char_phase = ntti_pkg::PH_FRAC;
                else if (is_exp)   char_phase = ntti_pkg::PH_EXP;
            end
            ntti_pkg::PH_EXP: begin
                if (is_sign)       char_phase = ntti_pkg::PH_EXPSIGN;
                else if (is_digit) char_phase = ntti_pkg::PH_EXPDIG;
            end
            ntti_pkg::PH_EXPSIGN, ntti_pkg::PH_EXPDIG: begin
                if (is_digit)      char_phase = ntti_pkg::PH_EXPDIG;
            end
            ntti_pkg::PH_BAD: begin
                char_phase = ntti_pkg::PH_BAD;
            end
        endcase
    end

    assign word_phase = i_item.has_char ? char_phase : i_phase;

    always_comb begin
        unique case (word_phase)
            ntti_pkg::PH_INT:
                grade = ntti_pkg::CLS_INT;
            ntti_pkg::PH_FRAC, ntti_pkg::PH_EXP, ntti_pkg::PH_EXPSIGN, ntti_pkg::PH_EXPDIG:
                grade = ntti_pkg::CLS_FLOAT;
            default:
                grade = ntti_pkg::CLS_STRING;
        endcase
    end

    always_comb begin
        merged = i_class;
        if (i_item.word_end && (grade > i_class)) begin
            merged = grade;
        end

        o_step.result = merged;
        priority if (i_item.last_word) begin
            o_step.phase = ntti_pkg::PH_START;
            o_step.cls   = ntti_pkg::CLS_INT;
        end else if (i_item.word_end) begin
            o_step.phase = ntti_pkg::PH_START;
            o_step.cls   = merged;
        end else begin
            o_step.phase = word_phase;
            o_step.cls   = merged;
        end
    end

endmodule

// ----- rtl/core/numeric_token_type_inference_core.sv -----
// Numeric token type inference core.
// Input i_in carries one beat per cycle while its ready is high: has_char marks a
// character in char_code, word_end closes the current word after that character,
// and last_word ends the set. Each word is graded integer, float or string, and
// the set keeps the worst grade. A beat with last_word set yields one beat on
// o_out whose data_type is 0 integer, 1 float or 2 string; other beats yield none.
// An accepted beat is loaded into the input register; processing it loads the
// result register, which drives o_out.
// Throughput: one beat per cycle while o_out is not stalled; the word recognizer
// and the set grade update combinationally between the input and result registers.
// While the receiver stalls, the pending result holds on o_out and one more
// beat may wait in the input register; after that i_in.ready drops until the
// result is taken. A synchronous active-low i_rst_n empties both registers and
// returns the recognizer to the start of a word with the set grade at integer.
`include "numeric_token_type_inference_core_defines.svh"

module numeric_token_type_inference_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ntti_in_if.sink           i_in,
    ntti_out_if.source        o_out
);

    logic                r_in_valid;
    ntti_pkg::t_item     r_in;
    logic                r_out_valid;
    ntti_pkg::t_class    r_out_type;
    ntti_pkg::t_phase    r_phase;
    ntti_pkg::t_class    r_class;

    logic                advance;
    logic                process;
    ntti_pkg::t_item     in_item;
    ntti_pkg::t_step     step;

    assign advance = !r_out_valid || o_out.ready;
    assign process = advance && r_in_valid;

    assign i_in.ready = !r_in_valid || advance;

    assign in_item.has_char  = i_in.has_char;
    assign in_item.char_code = i_in.char_code;
    assign in_item.word_end  = i_in.word_end;
    assign in_item.last_word = i_in.last_word;

    ntti_step u_step (
        .i_phase (r_phase),
        .i_class (r_class),
        .i_item  (r_in),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= ntti_pkg::PH_START;
            r_class     <= ntti_pkg::CLS_INT;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && r_in.last_word;
            end
            if (process) begin
                r_phase <= step.phase;
                r_class <= step.cls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out_type <= step.result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data_type = 2'(r_out_type);

    // A result beat starts a fresh set.
    `NTTI_ASSERT_NEXT(a_set_restart, i_clk, i_rst_n, process && r_in.last_word,
        (r_phase == ntti_pkg::PH_START) && (r_class == ntti_pkg::CLS_INT))
    // Within a set the grade never improves.
    `NTTI_ASSERT_NEXT(a_grade_monotonic, i_clk, i_rst_n, process && !r_in.last_word,
        r_class >= $past(r_class))
    // A stalled result freezes the recognizer.
    `NTTI_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, !advance,
        $stable(r_phase) && $stable(r_class))
    // Only the three defined classes ever leave the block.
    `NTTI_ASSERT_NOW(a_type_range, i_clk, i_rst_n, r_out_valid,
        (r_out_type == ntti_pkg::CLS_INT) || (r_out_type == ntti_pkg::CLS_FLOAT) ||
        (r_out_type == ntti_pkg::CLS_STRING))

endmodule

// ----- bench/tb_numeric_token_type_inference_core.sv -----
`default_nettype none

module tb_numeric_token_type_inference_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ntti_pkg::*;

    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;

    logic clk;
    logic rst_n;

    ntti_in_if  in_bus ();
    ntti_out_if out_bus ();

    numeric_token_type_inference_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_item  pending_beats[$];
    t_class expected_types[$];

    // Shadow of the recognizer state, advanced on every accepted beat.
    t_phase word_ph = PH_START;
    t_class set_cls = CLS_INT;

    int err_count     = 0;
    int cycle_count   = 0;
    int beats_offered = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    int holds_done    = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    t_item next_beat;
    t_class want;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_digit(logic [CODE_W-1:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic t_phase next_phase_of(t_phase ph, logic [CODE_W-1:0] c);
        bit sign_c;
        bit exp_c;
        sign_c = (c == C_PLUS) || (c == C_MINUS);
        exp_c  = (c == C_EXP_U) || (c == C_EXP_L);
        case (ph)
            PH_START: begin
                if (sign_c) return PH_SIGNED;
                if (is_digit(c)) return PH_INT;
                if (c == C_DOT) return PH_FRAC;
                return PH_BAD;
            end
            PH_SIGNED, PH_INT: begin
                if (is_digit(c)) return PH_INT;
                if (c == C_DOT) return PH_FRAC;
                return PH_BAD;
            end
            PH_FRAC: begin
                if (is_digit(c)) return PH_FRAC;
                if (exp_c) return PH_EXP;
                return PH_BAD;
            end
            PH_EXP: begin
                if (sign_c) return PH_EXPSIGN;
                if (is_digit(c)) return PH_EXPDIG;
                return PH_BAD;
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (is_digit(c)) return PH_EXPDIG;
                return PH_BAD;
            end
            default: return PH_BAD;
        endcase
    endfunction

    function automatic t_class word_grade_of(t_phase ph);
        case (ph)
            PH_INT: return CLS_INT;
            PH_FRAC, PH_EXP, PH_EXPSIGN, PH_EXPDIG: return CLS_FLOAT;
            default: return CLS_STRING;
        endcase
    endfunction

    task automatic grade_beat(t_item b);
        t_class g;
        if (b.has_char) word_ph = next_phase_of(word_ph, b.char_code);
        if (b.word_end) begin
            g = word_grade_of(word_ph);
            if (g > set_cls) set_cls = g;
            word_ph = PH_START;
        end
        if (b.last_word) begin
            expected_types.push_back(set_cls);
            word_ph = PH_START;
            set_cls = CLS_INT;
        end
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // ---------------- stimulus construction ----------------

    task automatic add_beat(bit hc, logic [CODE_W-1:0] code, bit we, bit lw);
        t_item b;
        b.has_char  = hc;
        b.char_code = code;
        b.word_end  = we;
        b.last_word = lw;
        pending_beats.push_back(b);
    endtask

    task automatic add_text(string s, bit we, bit lw);
        for (int i = 0; i < s.len(); i++) begin
            add_beat(1'b1, CODE_W'(s[i]), (i == s.len() - 1) && we,
                     (i == s.len() - 1) && lw);
        end
    endtask

    function automatic logic [CODE_W-1:0] any_code();
        return CODE_W'($urandom_range(0, 21'h1FFFFF));
    endfunction

    function automatic logic [CODE_W-1:0] pick_digit();
        return C_ZERO + CODE_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CODE_W-1:0] pick_sign();
        return ($urandom_range(0, 1) != 0) ? C_PLUS : C_MINUS;
    endfunction

    function automatic logic [CODE_W-1:0] pick_exp();
        return ($urandom_range(0, 1) != 0) ? C_EXP_U : C_EXP_L;
    endfunction

    function automatic logic [CODE_W-1:0] pick_any();
        case ($urandom_range(0, 7))
            0, 7: return pick_digit();
            1: return pick_sign();
            2: return C_DOT;
            3: return pick_exp();
            4: return any_code();
            5: return CODE_W'($urandom_range(32, 126));
            // A special character with a high bit set is no longer special.
            default: return C_DOT | (CODE_W'(1) << $urandom_range(7, CODE_W - 1));
        endcase
    endfunction

    // A character beat, sometimes preceded by a beat that carries no character.
    task automatic push_char(logic [CODE_W-1:0] code);
        if ($urandom_range(0, 11) == 0) add_beat(1'b0, any_code(), 1'b0, 1'b0);
        add_beat(1'b1, code, 1'b0, 1'b0);
    endtask

    task automatic push_float(bit with_exp);
        if ($urandom_range(0, 2) == 0) push_char(pick_sign());
        repeat ($urandom_range(0, 3)) push_char(pick_digit());
        push_char(C_DOT);
        repeat ($urandom_range(0, 3)) push_char(pick_digit());
        if (with_exp) begin
            push_char(pick_exp());
            if ($urandom_range(0, 1) != 0) push_char(pick_sign());
            repeat ($urandom_range(0, 3)) push_char(pick_digit());
        end
    endtask

    task automatic gen_word();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                if ($urandom_range(0, 2) == 0) push_char(pick_sign());
                repeat ($urandom_range(1, 6)) push_char(pick_digit());
            end
            3, 4: push_float($urandom_range(0, 1) != 0);
            5: begin
                if ($urandom_range(0, 1) != 0) push_char(pick_sign());
            end
            6: begin
                repeat ($urandom_range(0, 3)) push_char(pick_digit());
                push_char(pick_exp());
                repeat ($urandom_range(0, 2)) push_char(pick_digit());
            end
            7: repeat ($urandom_range(1, 5)) push_char(pick_any());
            8: begin
                push_float($urandom_range(0, 1) != 0);
                push_char(pick_any());
                repeat ($urandom_range(0, 2)) push_char(pick_digit());
            end
            default: begin
                push_float(1'b1);
                push_char(($urandom_range(0, 1) != 0) ? C_DOT : pick_exp());
            end
        endcase
    endtask

    task automatic mark_last(int since, bit we, bit lw);
        t_item b;
        if (pending_beats.size() == since) begin
            add_beat(1'b0, any_code(), we, lw);
        end else begin
            b = pending_beats.pop_back();
            b.word_end  = b.word_end | we;
            b.last_word = lw;
            pending_beats.push_back(b);
        end
    endtask

    task automatic gen_set();
        int set_start;
        int word_start;
        int nwords;
        set_start = pending_beats.size();
        nwords = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        repeat (nwords) begin
            word_start = pending_beats.size();
            gen_word();
            mark_last(word_start, 1'b1, 1'b0);
        end
        case ($urandom_range(0, 7))
            0: add_beat(1'b0, any_code(), $urandom_range(0, 1), 1'b1);
            1: begin
                // The open word is dropped by the set end.
                word_start = pending_beats.size();
                gen_word();
                mark_last(word_start, 1'b0, 1'b1);
            end
            default: mark_last(set_start, 1'b0, 1'b1);
        endcase
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(negedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (in_bus.valid && beats_taken != beats_offered) begin
            // Beat still waiting for ready; hold it.
        end else if (gap_left > 0) begin
            in_bus.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end else if (pending_beats.size() != 0) begin
            next_beat = pending_beats.pop_front();
            in_bus.has_char  <= next_beat.has_char;
            in_bus.char_code <= next_beat.char_code;
            in_bus.word_end  <= next_beat.word_end;
            in_bus.last_word <= next_beat.last_word;
            in_bus.valid     <= 1'b1;
            beats_offered    <= beats_offered + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 48);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap_left <= 0;
                    5, 6, 7: gap_left <= $urandom_range(1, 3);
                    default: gap_left <= $urandom_range(4, 12);
                endcase
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if ((holds_done == 0 && results_seen >= 15) ||
                     (holds_done == 1 && results_seen >= 80)) begin
            // Long hold-off so that the core backs up and drops its input ready.
            out_bus.ready <= 1'b0;
            hold_left     <= LONG_HOLD;
            holds_done    <= holds_done + 1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0: out_bus.ready <= 1'b1;
                1: out_bus.ready <= $urandom_range(0, 1);
                2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                default: out_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                results_seen <= results_seen + 1;
                if (expected_types.size() == 0) begin
                    report_mismatch($sformatf("result beat data_type %0d with none expected",
                                              out_bus.data_type));
                end else begin
                    want = expected_types.pop_front();
                    if (out_bus.data_type !== want) begin
                        report_mismatch($sformatf("data_type %0d, expected %0d (%s)",
                                                  out_bus.data_type, want, want.name()));
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                beats_taken <= beats_taken + 1;
                grade_beat('{has_char: in_bus.has_char, char_code: in_bus.char_code,
                             word_end: in_bus.word_end, last_word: in_bus.last_word});
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d beats left, %0d results outstanding",
                     pending_beats.size(), expected_types.size());
            $display("tb_numeric_token_type_inference_core: done, errors");
            $finish;
        end
    end

    initial begin
        int directed_beats;
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.has_char   = 1'b0;
        in_bus.char_code  = '0;
        in_bus.word_end   = 1'b0;
        in_bus.last_word  = 1'b0;
        out_bus.ready     = 1'b0;

        // Directed sets: empty word, empty set, bare sign, bare dot, exponent
        // forms with and without a dot, non-ASCII codes and dropped words.
        add_beat(1'b0, '0, 1'b1, 1'b1);
        add_beat(1'b0, '0, 1'b0, 1'b1);
        add_text("-9", 1'b1, 1'b1);
        add_text("+", 1'b1, 1'b1);
        add_text(".", 1'b1, 1'b1);
        add_text("-0.e", 1'b1, 1'b1);
        add_text(".e+5", 1'b1, 1'b1);
        add_text("E", 1'b1, 1'b0);
        add_text("1e", 1'b1, 1'b1);
        add_beat(1'b1, 21'h1FFFFF, 1'b1, 1'b0);
        add_text("7", 1'b1, 1'b1);
        add_text("5.", 1'b0, 1'b0);
        add_beat(1'b0, '0, 1'b0, 1'b1);
        add_beat(1'b1, 21'h100031, 1'b1, 1'b1);
        add_beat(1'b0, 21'h1FFFFF, 1'b0, 1'b0);
        add_text("3", 1'b1, 1'b1);
        directed_beats = pending_beats.size();

        while (pending_beats.size() < directed_beats + RANDOM_BEATS) gen_set();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || beats_taken != beats_offered) @(posedge clk);
        while (expected_types.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        if (err_count == 0) begin
            $display("tb_numeric_token_type_inference_core: done, clean");
        end else begin
            $display("tb_numeric_token_type_inference_core: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
